[hw/rtl/kcc_pkg.sv]
// Shared types and constants of the key click classifier.
// No dependencies; used by kcc_key and key_click_classifier_top.
package kcc_pkg;

  // Width of the pin field; keys beyond it never read as pressed
  localparam int unsigned PinWidth  = 6;
  localparam int unsigned FlagWidth = 7;

  // Event flag encoding
  localparam logic [FlagWidth-1:0] FLAG_HOLD   = 7'h01;
  localparam logic [FlagWidth-1:0] FLAG_DOWN   = 7'h02;
  localparam logic [FlagWidth-1:0] FLAG_UP     = 7'h04;
  localparam logic [FlagWidth-1:0] FLAG_SINGLE = 7'h08;
  localparam logic [FlagWidth-1:0] FLAG_DOUBLE = 7'h10;
  localparam logic [FlagWidth-1:0] FLAG_LONG   = 7'h20;
  localparam logic [FlagWidth-1:0] FLAG_REPEAT = 7'h40;

  // Operation codes carried in tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DOUBLE_WINDOW   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_TIME = 2'd1;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;
  localparam logic [1:0] REG_SCAN_DIVIDER    = 2'd3;

  // Register reset values
  localparam logic [7:0] DOUBLE_WINDOW_RST   = 8'd10;
  localparam logic [7:0] LONG_PRESS_TIME_RST = 8'd50;
  localparam logic [7:0] REPEAT_INTERVAL_RST = 8'd10;
  localparam logic [7:0] SCAN_DIVIDER_RST    = 8'd5;

  typedef struct packed {
    logic [7:0] double_window;
    logic [7:0] long_press_time;
    logic [7:0] repeat_interval;
    logic [7:0] scan_divider;
  } kcc_cfg_t;

  // Per-key control for one processed request
  typedef struct packed {
    logic tick;     // timer countdown
    logic scan;     // sample pin and step the machine (only with tick)
    logic pressed;  // sampled pin, active high
    logic clear;    // clear the masked flags
  } kcc_key_ctrl_t;

endpackage

[hw/rtl/key_click_classifier_top.sv]
// Key click classifier top level: stream ports, APB registers, key array.
// Depends on kcc_pkg and kcc_key.
//
// Takes one request per clock cycle while the output is not stalled and returns
// one result per request: the request is held in an input register, all keys
// are updated in parallel in a single combinational stage, and the result is
// captured in an output register. A tick request (tuser 0) counts down the key
// timers and, every scan_divider-th tick, samples the active-low pins and steps
// each key's click machine; it returns a zero result. A check request (tuser 1)
// returns the addressed key's flags and whether any masked flag was set, then
// clears those flags unless the mask is hold alone. The user must write the
// registers through APB only while the stream is idle; the block itself does
// not enforce this.
module key_click_classifier_top #(
  parameter int unsigned NUM_KEYS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pin_levels[5:0], key_index[8:6], flag_mask[15:9]
  input  logic        s_axis_tuser,  // operation: 0 tick, 1 check
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // check_hit[0], key_flags[7:1]
);
  import kcc_pkg::*;

  // Configuration registers
  kcc_cfg_t cfg_q;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.double_window   <= DOUBLE_WINDOW_RST;
      cfg_q.long_press_time <= LONG_PRESS_TIME_RST;
      cfg_q.repeat_interval <= REPEAT_INTERVAL_RST;
      cfg_q.scan_divider    <= SCAN_DIVIDER_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DOUBLE_WINDOW:   cfg_q.double_window   <= pwdata[7:0];
        REG_LONG_PRESS_TIME: cfg_q.long_press_time <= pwdata[7:0];
        REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= pwdata[7:0];
        REG_SCAN_DIVIDER:    cfg_q.scan_divider    <= pwdata[7:0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DOUBLE_WINDOW:   prdata = {24'd0, cfg_q.double_window};
      REG_LONG_PRESS_TIME: prdata = {24'd0, cfg_q.long_press_time};
      REG_REPEAT_INTERVAL: prdata = {24'd0, cfg_q.repeat_interval};
      REG_SCAN_DIVIDER:    prdata = {24'd0, cfg_q.scan_divider};
      default:             prdata = 32'd0;
    endcase
  end

  // Input register
  logic                 in_valid_q;
  logic                 in_op_q;
  logic [PinWidth-1:0]  in_pins_q;
  logic [2:0]           in_idx_q;
  logic [FlagWidth-1:0] in_mask_q;
  logic                 out_valid_q;
  logic                 advance;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_pins_q <= s_axis_tdata[5:0];
      in_idx_q  <= s_axis_tdata[8:6];
      in_mask_q <= s_axis_tdata[15:9];
    end
  end

  // Scan prescaler
  logic [7:0] prescale_q, prescale_inc;
  logic       do_tick, do_check, do_scan;

  assign do_tick      = advance & (in_op_q == OP_TICK);
  assign do_check     = advance & (in_op_q == OP_CHECK);
  assign prescale_inc = prescale_q + 8'd1;
  assign do_scan      = do_tick & (prescale_inc >= cfg_q.scan_divider);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= 8'd0;
    end else if (do_tick) begin
      prescale_q <= do_scan ? 8'd0 : prescale_inc;
    end
  end

  // Check lookup: select the addressed key's flags
  logic [FlagWidth-1:0] key_flags [NUM_KEYS];
  logic [FlagWidth-1:0] sel_flags;
  logic                 idx_ok, hit, clear_ok;

  assign idx_ok = 32'(in_idx_q) < NUM_KEYS;

  always_comb begin
    sel_flags = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(in_idx_q) == k) begin
        sel_flags = sel_flags | key_flags[k];
      end
    end
  end

  assign hit      = idx_ok & ((sel_flags & in_mask_q) != '0);
  assign clear_ok = do_check & hit & (in_mask_q != FLAG_HOLD);

  // Key array
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kcc_key_ctrl_t ctrl;
    logic          pressed;

    if (k < PinWidth) begin : g_pin
      assign pressed = ~in_pins_q[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    assign ctrl.tick    = do_tick;
    assign ctrl.scan    = do_scan;
    assign ctrl.pressed = pressed;
    assign ctrl.clear   = clear_ok & (32'(in_idx_q) == k);

    kcc_key u_key (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (cfg_q),
      .ctrl_i       (ctrl),
      .clear_mask_i (in_mask_q),
      .flags_o      (key_flags[k])
    );
  end

  // Result register
  logic                 out_hit_q;
  logic [FlagWidth-1:0] out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q   <= do_check & hit;
      out_flags_q <= (do_check && idx_ok) ? sel_flags : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_flags_q, out_hit_q};

  // Assertions
  a_tick_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_tick |=> (m_axis_tvalid && m_axis_tdata == 8'd0))
    else $error("tick request produced a nonzero result");

  a_scan_clears_prescale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_scan |=> (prescale_q == 8'd0))
    else $error("prescaler not cleared after a scan");

  a_hit_has_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[7:1] != 7'd0))
    else $error("check hit reported with no flags");

  a_out_range_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_check && !idx_ok) |=> (m_axis_tdata == 8'd0))
    else $error("out of range key reported a result");

endmodule

[hw/rtl/kcc_key.sv]
// One key: press timer, five-state click machine and sticky event flags.
// Depends on kcc_pkg.
module kcc_key (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kcc_pkg::kcc_cfg_t              cfg_i,
  input  kcc_pkg::kcc_key_ctrl_t         ctrl_i,
  input  logic [kcc_pkg::FlagWidth-1:0]  clear_mask_i,
  output logic [kcc_pkg::FlagWidth-1:0]  flags_o
);
  import kcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESSED = 3'd1,
    ST_WAIT    = 3'd2,
    ST_SECOND  = 3'd3,
    ST_LONG    = 3'd4
  } click_state_e;

  click_state_e         state_q, state_d;
  logic [7:0]           timer_q, timer_d, timer_dec;
  logic                 cur_q, cur_d;
  logic [FlagWidth-1:0] flags_q, flags_d;

  // Next-state logic: countdown first, then the scan step sees the new timer
  always_comb begin
    timer_dec = (timer_q != 8'd0) ? (timer_q - 8'd1) : timer_q;
    state_d   = state_q;
    timer_d   = timer_q;
    cur_d     = cur_q;
    flags_d   = flags_q;

    if (ctrl_i.tick) begin
      timer_d = timer_dec;
    end

    if (ctrl_i.scan) begin
      cur_d = ctrl_i.pressed;
      if (ctrl_i.pressed) begin
        flags_d = flags_d | FLAG_HOLD;
      end else begin
        flags_d = flags_d & ~FLAG_HOLD;
      end
      if (ctrl_i.pressed && !cur_q) begin
        flags_d = flags_d | FLAG_DOWN;
      end
      if (!ctrl_i.pressed && cur_q) begin
        flags_d = flags_d | FLAG_UP;
      end

      case (state_q)
        ST_IDLE: begin
          if (ctrl_i.pressed) begin
            timer_d = cfg_i.long_press_time;
            state_d = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (!ctrl_i.pressed) begin
            timer_d = cfg_i.double_window;
            state_d = ST_WAIT;
          end else if (timer_dec == 8'd0) begin
            timer_d = cfg_i.repeat_interval;
            flags_d = flags_d | FLAG_LONG;
            state_d = ST_LONG;
          end
        end
        ST_WAIT: begin
          if (ctrl_i.pressed) begin
            flags_d = flags_d | FLAG_DOUBLE;
            state_d = ST_SECOND;
          end else if (timer_dec == 8'd0) begin
            flags_d = flags_d | FLAG_SINGLE;
            state_d = ST_IDLE;
          end
        end
        ST_SECOND: begin
          if (!ctrl_i.pressed) begin
            state_d = ST_IDLE;
          end
        end
        ST_LONG: begin
          if (!ctrl_i.pressed) begin
            state_d = ST_IDLE;
          end else if (timer_dec == 8'd0) begin
            timer_d = cfg_i.repeat_interval;
            flags_d = flags_d | FLAG_REPEAT;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end

    // A check request clears the masked flags
    if (ctrl_i.clear) begin
      flags_d = flags_q & ~clear_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      timer_q <= 8'd0;
      cur_q   <= 1'b0;
      flags_q <= '0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      cur_q   <= cur_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

[tb/sv/kcc_click_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the key click classifier: follows APB register writes,
// predicts the result of each accepted request and compares the result stream.
// Depends on kcc_pkg.
module kcc_click_checker
  import kcc_pkg::*;
#(
  parameter int unsigned NumKeys = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port, observed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // Request stream, observed
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pin_levels[5:0], key_index[8:6], flag_mask[15:9]
  input  logic        s_axis_tuser,  // operation: 0 tick, 1 check
  // Result stream, observed
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // check_hit[0], key_flags[7:1]
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [2:0] {
    KEY_IDLE,
    KEY_PRESSED,
    KEY_RELEASED_WAIT,
    KEY_SECOND_PRESS,
    KEY_LONG_HELD
  } key_phase_e;

  // Same layout as the result tdata: hit in bit 0
  typedef struct packed {
    logic [FlagWidth-1:0] flags;
    logic                 hit;
  } click_result_t;

  // Shadow of the block's registers and per-key state
  kcc_cfg_t             cfg_q;
  logic [7:0]           prescale_q;
  logic                 pressed_q [NumKeys];
  key_phase_e           phase_q   [NumKeys];
  logic [7:0]           timer_q   [NumKeys];
  logic [FlagWidth-1:0] flags_q   [NumKeys];

  click_result_t expected_q [$];
  int unsigned   fails;

  // Apply one request to the shadow state and return the result it must give
  function automatic click_result_t predict_click_result(input logic op,
                                                         input logic [15:0] data);
    click_result_t        res;
    logic [5:0]           pins;
    logic [2:0]           key;
    logic [6:0]           mask;
    logic                 now;
    logic                 was;
    logic [FlagWidth-1:0] fl;
    key_phase_e           st;
    res  = '0;
    pins = data[5:0];
    key  = data[8:6];
    mask = data[15:9];
    if (op == OP_TICK) begin
      for (int unsigned k = 0; k < NumKeys; k++) begin
        if (timer_q[k] != '0) timer_q[k]--;
      end
      prescale_q++;
      if (prescale_q >= cfg_q.scan_divider) begin
        prescale_q = '0;
        for (int unsigned k = 0; k < NumKeys; k++) begin
          // pins are active low; keys past the pin field stay released
          now = (k < PinWidth) ? !pins[k] : 1'b0;
          was = pressed_q[k];
          pressed_q[k] = now;
          fl = flags_q[k];
          st = phase_q[k];
          if (now) begin
            fl |= FLAG_HOLD;
          end else begin
            fl &= ~FLAG_HOLD;
          end
          if (now && !was) fl |= FLAG_DOWN;
          if (!now && was) fl |= FLAG_UP;
          case (st)
            KEY_IDLE: begin
              if (now) begin
                timer_q[k] = cfg_q.long_press_time;
                st = KEY_PRESSED;
              end
            end
            KEY_PRESSED: begin
              if (!now) begin
                timer_q[k] = cfg_q.double_window;
                st = KEY_RELEASED_WAIT;
              end else if (timer_q[k] == '0) begin
                timer_q[k] = cfg_q.repeat_interval;
                fl |= FLAG_LONG;
                st = KEY_LONG_HELD;
              end
            end
            KEY_RELEASED_WAIT: begin
              if (now) begin
                fl |= FLAG_DOUBLE;
                st = KEY_SECOND_PRESS;
              end else if (timer_q[k] == '0) begin
                fl |= FLAG_SINGLE;
                st = KEY_IDLE;
              end
            end
            KEY_SECOND_PRESS: begin
              if (!now) st = KEY_IDLE;
            end
            KEY_LONG_HELD: begin
              if (!now) begin
                st = KEY_IDLE;
              end else if (timer_q[k] == '0) begin
                timer_q[k] = cfg_q.repeat_interval;
                fl |= FLAG_REPEAT;
              end
            end
            default: ;
          endcase
          phase_q[k] = st;
          flags_q[k] = fl;
        end
      end
    end else if (key < NumKeys) begin
      // check: report flags, clear the asked ones unless only hold was asked
      res.flags = flags_q[key];
      if ((flags_q[key] & mask) != '0) begin
        res.hit = 1'b1;
        if (mask != FLAG_HOLD) flags_q[key] &= ~mask;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    click_result_t got;
    click_result_t want;
    if (!rst_ni) begin
      cfg_q.double_window   = DOUBLE_WINDOW_RST;
      cfg_q.long_press_time = LONG_PRESS_TIME_RST;
      cfg_q.repeat_interval = REPEAT_INTERVAL_RST;
      cfg_q.scan_divider    = SCAN_DIVIDER_RST;
      prescale_q = '0;
      for (int unsigned k = 0; k < NumKeys; k++) begin
        pressed_q[k] = 1'b0;
        phase_q[k]   = KEY_IDLE;
        timer_q[k]   = '0;
        flags_q[k]   = '0;
      end
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DOUBLE_WINDOW:   cfg_q.double_window   = pwdata[7:0];
          REG_LONG_PRESS_TIME: cfg_q.long_press_time = pwdata[7:0];
          REG_REPEAT_INTERVAL: cfg_q.repeat_interval = pwdata[7:0];
          REG_SCAN_DIVIDER:    cfg_q.scan_divider    = pwdata[7:0];
          default: ;
        endcase
      end
      // compare each result with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("unexpected result: check_hit %0d key_flags %h", got.hit, got.flags);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) begin
            $error("check_hit mismatch: expected %0d, actual %0d", want.hit, got.hit);
            fails++;
          end
          if (got.flags !== want.flags) begin
            $error("key_flags mismatch: expected %h, actual %h", want.flags, got.flags);
            fails++;
          end
        end
      end
      // predict each accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_click_result(s_axis_tuser, s_axis_tdata));
      end
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the key click classifier testbench: clock, reset, request and result
// drivers with random gaps, APB register phases and the final verdict.
// Depends on kcc_pkg, key_click_classifier_top and kcc_click_checker.
module tb;
  import kcc_pkg::*;

  localparam int unsigned NumKeys = 6;
  localparam logic [FlagWidth-1:0] MaskAll = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  int unsigned fail_count;
  int unsigned pending;

  // Stimulus controls
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_hold_req;
  bit          stream_ok;
  logic [5:0]  pin_now;
  int unsigned pin_left [NumKeys];
  int unsigned span_short;
  int unsigned span_long;

  key_click_classifier_top #(
    .NUM_KEYS(NumKeys)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  kcc_click_checker #(
    .NumKeys(NumKeys)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random wait per result, plus one long hold on request
  initial begin : result_sink
    int unsigned wait_left;
    m_axis_tready = 1'b0;
    wait_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        wait_left = 60;
        rx_hold_req = 1'b0;
      end
      if (wait_left > 0) begin
        m_axis_tready <= 1'b0;
        wait_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        wait_left = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
    end
  end

  // Offer one request after a random gap and wait for it to be taken
  task automatic send_req(input logic op, input logic [15:0] data);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Unused fields of a request carry random bits
  task automatic send_tick(input logic [5:0] pins);
    send_req(OP_TICK, {7'($urandom), 3'($urandom), pins});
  endtask

  task automatic send_check(input logic [2:0] key, input logic [6:0] mask);
    send_req(OP_CHECK, {mask, key, 6'($urandom)});
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_stream(output bit drained);
    int unsigned waited;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 4000) begin
      @(negedge clk_i);
      waited++;
    end
    drained = (pending == 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Idle the stream, write all registers, size the key press durations
  task automatic reconfigure(input logic [7:0] dw, input logic [7:0] lp,
                             input logic [7:0] rep, input logic [7:0] div);
    bit drained;
    drain_stream(drained);
    if (!drained) stream_ok = 1'b0;
    repeat (4) @(negedge clk_i);
    write_reg(REG_DOUBLE_WINDOW, dw);
    write_reg(REG_LONG_PRESS_TIME, lp);
    write_reg(REG_REPEAT_INTERVAL, rep);
    write_reg(REG_SCAN_DIVIDER, div);
    span_short = dw + 2 * div + 2;
    span_long  = lp + 3 * rep + 3 * div + 2;
    if (span_short > 300) span_short = 300;
    if (span_long > 300) span_long = 300;
  endtask

  // Mostly realistic key activity with random checks; a bit of pin noise
  task automatic run_phase(input int n, input int hold_at);
    int unsigned pick;
    int unsigned sel;
    logic [6:0]  mask;
    logic [2:0]  key;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      // long result stall while requests keep coming
      if (i == hold_at) begin
        tx_idle_on = 1'b0;
        rx_hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        for (int k = 0; k < NumKeys; k++) begin
          if (pin_left[k] == 0) begin
            pin_now[k] = ~pin_now[k];
            pin_left[k] = $urandom_range(0, 1) ? $urandom_range(1, span_short)
                                                : $urandom_range(1, span_long);
          end else begin
            pin_left[k]--;
          end
        end
        send_tick(pin_now);
      end else if (pick < 70) begin
        send_tick(6'($urandom));
      end else begin
        key = (pick < 95) ? 3'($urandom_range(0, NumKeys - 1)) : 3'($urandom_range(6, 7));
        sel = $urandom_range(0, 9);
        case (sel)
          0:       mask = FLAG_HOLD;
          1:       mask = '0;
          2:       mask = MaskAll;
          3, 4, 5: mask = 7'(1 << $urandom_range(0, FlagWidth - 1));
          default: mask = 7'($urandom);
        endcase
        send_check(key, mask);
      end
    end
  endtask

  initial begin : stimulus
    bit drained;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    rx_hold_req   = 1'b0;
    stream_ok     = 1'b1;
    pin_now       = '1;
    for (int k = 0; k < NumKeys; k++) pin_left[k] = 0;
    span_short    = 22;
    span_long     = 97;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: out-of-range keys, empty mask, hold-only reads, edges
    send_check(3'd6, MaskAll);
    send_check(3'd7, MaskAll);
    send_check(3'd0, '0);
    repeat (5) send_tick(6'h00);
    send_check(3'd0, FLAG_HOLD);
    send_check(3'd0, FLAG_HOLD);
    send_check(3'd1, FLAG_DOWN | FLAG_HOLD);
    send_check(3'd2, '0);
    repeat (5) send_tick(6'h3F);
    send_check(3'd3, FLAG_UP);
    send_check(3'd5, MaskAll);
    repeat (5) send_tick(6'h15);
    send_check(3'd4, FLAG_DOWN);

    // Random phases over several register settings, extremes included
    reconfigure(DOUBLE_WINDOW_RST, LONG_PRESS_TIME_RST, REPEAT_INTERVAL_RST,
                SCAN_DIVIDER_RST);
    run_phase(300, -1);
    reconfigure(8'd1, 8'd1, 8'd1, 8'd1);
    run_phase(250, -1);
    reconfigure(8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(200, -1);
    reconfigure(8'd255, 8'd255, 8'd255, 8'd255);
    run_phase(400, -1);
    reconfigure(8'd2, 8'd6, 8'd2, 8'd1);
    run_phase(300, 120);
    reconfigure(8'($urandom_range(0, 12)), 8'($urandom_range(0, 24)),
                8'($urandom_range(0, 6)), 8'($urandom_range(0, 3)));
    run_phase(250, -1);

    drain_stream(drained);
    if (!drained) stream_ok = 1'b0;
    repeat (8) @(negedge clk_i);
    if (stream_ok && fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
